### sv/bdot_detumble_coil_currents_unit_defines.svh
// Assertion macros shared by the detumble coil current block
`ifndef BDOT_DETUMBLE_COIL_CURRENTS_UNIT_DEFINES_SVH
`define BDOT_DETUMBLE_COIL_CURRENTS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BDCC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define BDCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bdcc_pkg.sv
// Package: payload types, control bundle and fixed widths of the detumble block
`timescale 1ns / 1ps

package bdcc_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int ALPHA_BITS  = 15;
   localparam int ALPHA_W     = ALPHA_BITS + 1;
   localparam int GAIN_W      = 32;
   localparam int CUR_W       = 32;
   localparam int DIFF_W      = SAMPLE_BITS + 1;
   localparam int PRODA_W     = ALPHA_W + 1 + DIFF_W;
   localparam int BLEND_W     = DIFF_W + ALPHA_BITS + 1;
   localparam int MAG_W       = BLEND_W - 1;
   localparam int SPLIT_W     = MAG_W / 2;
   localparam int PP_W        = GAIN_W + MAG_W - SPLIT_W;
   localparam int PROD_W      = GAIN_W + MAG_W;
   localparam int DIV_W       = SAMPLE_BITS + ALPHA_BITS;
   localparam int QUO_BITS    = CUR_W - 1;
   localparam int CSR_IDX_W   = 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;
   localparam logic [CUR_W-1:0]   CUR_MAX   = {1'b0, {(CUR_W-1){1'b1}}};
   localparam logic [CUR_W-1:0]   CUR_MIN   = {1'b1, {(CUR_W-1){1'b0}}};

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COIL_GAIN    = 1'd1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] field_x;
      logic signed [SAMPLE_BITS-1:0] field_y;
      logic signed [SAMPLE_BITS-1:0] field_z;
      logic signed [SAMPLE_BITS-1:0] last_field_x;
      logic signed [SAMPLE_BITS-1:0] last_field_y;
      logic signed [SAMPLE_BITS-1:0] last_field_z;
      logic        [SAMPLE_BITS-1:0] field_norm;
   } bdcc_req_type;

   typedef struct packed {
      logic signed [CUR_W-1:0] coil_current_x;
      logic signed [CUR_W-1:0] coil_current_y;
      logic signed [CUR_W-1:0] coil_current_z;
      logic                    norm_zero;
   } bdcc_rsp_type;

   // One strobe per lane phase; at most one is high in a cycle
   typedef struct packed {
      logic load;
      logic mul;
      logic sum;
      logic mag;
      logic plo;
      logic phi;
      logic add;
      logic chk;
      logic step;
   } bdcc_ctl_type;

endpackage

### sv/bdcc_lane.sv
// One axis lane: difference, blend, gain product and restoring divide
`timescale 1ns / 1ps
`include "bdot_detumble_coil_currents_unit_defines.svh"

module bdcc_lane (
   input  logic                                       clock,
   input  logic                                       reset,
   input  bdcc_pkg::bdcc_ctl_type                     ctl,
   input  logic        [bdcc_pkg::ALPHA_W-1:0]        alpha,
   input  logic        [bdcc_pkg::ALPHA_W-1:0]        beta,
   input  logic        [bdcc_pkg::GAIN_W-1:0]         gain,
   input  logic        [bdcc_pkg::DIV_W-1:0]          divisor,
   input  logic signed [bdcc_pkg::SAMPLE_BITS-1:0]    field,
   input  logic signed [bdcc_pkg::SAMPLE_BITS-1:0]    last_field,
   output logic signed [bdcc_pkg::CUR_W-1:0]          current
);

   logic signed [bdcc_pkg::DIFF_W-1:0]  cur_d_ff;
   logic signed [bdcc_pkg::DIFF_W-1:0]  prior_ff;
   logic signed [bdcc_pkg::PRODA_W-1:0] pa_ff;
   logic signed [bdcc_pkg::PRODA_W-1:0] pb_ff;
   logic signed [bdcc_pkg::BLEND_W-1:0] blend_ff;
   logic        [bdcc_pkg::MAG_W-1:0]   mag_ff;
   logic                                neg_ff;
   logic        [bdcc_pkg::PP_W-1:0]    plo_ff;
   logic        [bdcc_pkg::PP_W-1:0]    phi_ff;
   logic        [bdcc_pkg::PROD_W-1:0]  prod_ff;
   logic                                sat_ff;
   logic        [bdcc_pkg::DIV_W-1:0]   rem_ff;
   logic        [bdcc_pkg::QUO_BITS-1:0] sh_ff;

   logic signed [bdcc_pkg::DIFF_W-1:0]  diff_in;
   logic signed [bdcc_pkg::PRODA_W-1:0] sum_full;
   logic signed [bdcc_pkg::BLEND_W-1:0] blend_neg;
   logic        [bdcc_pkg::PROD_W-bdcc_pkg::QUO_BITS-1:0] prod_hi;
   logic        [bdcc_pkg::DIV_W:0]     trial;
   logic                                trial_ge;
   logic        [bdcc_pkg::DIV_W:0]     trial_sub;
   logic        [bdcc_pkg::CUR_W-1:0]   q_ext;

   assign diff_in   = bdcc_pkg::DIFF_W'(field) - bdcc_pkg::DIFF_W'(last_field);
   assign sum_full  = pa_ff + pb_ff;
   assign blend_neg = -blend_ff;
   assign prod_hi   = prod_ff[bdcc_pkg::PROD_W-1:bdcc_pkg::QUO_BITS];
   assign trial     = {rem_ff, sh_ff[bdcc_pkg::QUO_BITS-1]};
   assign trial_ge  = trial >= {1'b0, divisor};
   assign trial_sub = trial - {1'b0, divisor};
   assign q_ext     = {1'b0, sh_ff};

   // Prior difference is block state: cleared by reset, replaced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff <= '0;
      end else if (ctl.mul) begin
         prior_ff <= cur_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cur_d_ff <= diff_in;
      end
      if (ctl.mul) begin
         pa_ff <= $signed({1'b0, alpha}) * cur_d_ff;
         pb_ff <= $signed({1'b0, beta}) * prior_ff;
      end
      if (ctl.sum) begin
         blend_ff <= sum_full[bdcc_pkg::BLEND_W-1:0];
      end
      if (ctl.mag) begin
         neg_ff <= blend_ff[bdcc_pkg::BLEND_W-1];
         mag_ff <= blend_ff[bdcc_pkg::BLEND_W-1] ? blend_neg[bdcc_pkg::MAG_W-1:0]
                                                 : blend_ff[bdcc_pkg::MAG_W-1:0];
      end
      if (ctl.plo) begin
         plo_ff <= gain * mag_ff[bdcc_pkg::SPLIT_W-1:0];
      end
      if (ctl.phi) begin
         phi_ff <= gain * mag_ff[bdcc_pkg::MAG_W-1:bdcc_pkg::SPLIT_W];
      end
      if (ctl.add) begin
         prod_ff <= {phi_ff, bdcc_pkg::SPLIT_W'(0)} + bdcc_pkg::PROD_W'(plo_ff);
      end
      if (ctl.chk) begin
         // quotient of 2^31 or more saturates; else remainder starts below divisor
         sat_ff <= prod_hi >= {{(bdcc_pkg::PROD_W-bdcc_pkg::QUO_BITS-bdcc_pkg::DIV_W){1'b0}},
                               divisor};
         rem_ff <= prod_hi[bdcc_pkg::DIV_W-1:0];
         sh_ff  <= prod_ff[bdcc_pkg::QUO_BITS-1:0];
      end else if (ctl.step) begin
         rem_ff <= trial_ge ? trial_sub[bdcc_pkg::DIV_W-1:0] : trial[bdcc_pkg::DIV_W-1:0];
         sh_ff  <= {sh_ff[bdcc_pkg::QUO_BITS-2:0], trial_ge};
      end
   end

   // Control law negates: a negative blend gives a positive current
   always_comb begin
      if (sat_ff) begin
         current = neg_ff ? bdcc_pkg::CUR_MAX : bdcc_pkg::CUR_MIN;
      end else begin
         current = neg_ff ? q_ext : -q_ext;
      end
   end

   `BDCC_ASSERT_IMPLY(a_rem_below_divisor, clock, reset, ctl.step && !sat_ff,
      rem_ff < divisor, "lane remainder reached the divisor during the divide")

endmodule

### sv/bdcc_merge.sv
// Merge stage: gather the three lane currents and the zero-norm flag into the result register
`timescale 1ns / 1ps

module bdcc_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [bdcc_pkg::CUR_W-1:0]    cur_x,
   input  logic signed [bdcc_pkg::CUR_W-1:0]    cur_y,
   input  logic signed [bdcc_pkg::CUR_W-1:0]    cur_z,
   input  logic                                 norm_zero,
   output logic                                 free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bdcc_pkg::bdcc_rsp_type               rsp_data
);

   logic                    valid_ff;
   logic                    valid_in;
   bdcc_pkg::bdcc_rsp_type  data_ff;

   assign free      = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Zero norm forces all currents to zero
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.coil_current_x <= norm_zero ? '0 : cur_x;
         data_ff.coil_current_y <= norm_zero ? '0 : cur_y;
         data_ff.coil_current_z <= norm_zero ? '0 : cur_z;
         data_ff.norm_zero      <= norm_zero;
      end
   end

endmodule

### sv/bdot_detumble_coil_currents_unit.sv
// Top level of the B-dot detumble coil current block: sequencer, registers and lanes
`timescale 1ns / 1ps
`include "bdot_detumble_coil_currents_unit_defines.svh"

// B-dot detumble coil currents. Each item carries the present and the previous
// three-axis magnetometer sample and the field magnitude. Per axis the block
// forms the field difference, blends it with the difference kept from the item
// before (weight filter_alpha in Q1.15, values above one act as one), and
// returns -coil_gain * blend / field_norm in Q16.16, truncated toward zero and
// saturated to 32 bits. A zero norm returns zero currents with norm_zero set;
// the stored differences are updated either way. Three identical lanes, one
// per axis, run side by side and a merge stage packs their currents into the
// result register. From acceptance an item runs through six steps of blend
// and gain product (the 32 x 40 bit product is formed as two 32 x 20 bit
// halves), a step to check for saturation and seed the divider, the
// restoring divider, one quotient bit a cycle, a step to load the result
// register once it is free, and the idle state in which the next item is
// taken. The input stalls while an item is in the lanes; the result
// register frees the lanes, so a waiting result does not hold off the next
// item, only its final load. Configuration writes take effect at once and
// belong while the block is idle. Reset: filter_alpha one, coil_gain one in
// Q(FRACTION_BITS), stored differences zero.

module bdot_detumble_coil_currents_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  bdcc_pkg::bdcc_req_type                req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output bdcc_pkg::bdcc_rsp_type                rsp_data,
   input  logic                                  csr_we,
   input  logic [bdcc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bdcc_pkg::GAIN_W-1:0]           csr_wdata
);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] ST_IDLE = 4'd0;
   localparam logic [STATE_W-1:0] ST_MUL  = 4'd1;
   localparam logic [STATE_W-1:0] ST_SUM  = 4'd2;
   localparam logic [STATE_W-1:0] ST_MAG  = 4'd3;
   localparam logic [STATE_W-1:0] ST_PLO  = 4'd4;
   localparam logic [STATE_W-1:0] ST_PHI  = 4'd5;
   localparam logic [STATE_W-1:0] ST_ADD  = 4'd6;
   localparam logic [STATE_W-1:0] ST_CHK  = 4'd7;
   localparam logic [STATE_W-1:0] ST_DIV  = 4'd8;
   localparam logic [STATE_W-1:0] ST_FIN  = 4'd9;

   localparam int CNT_W = $clog2(bdcc_pkg::QUO_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bdcc_pkg::QUO_BITS - 1);

   logic [STATE_W-1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]                     cnt_ff, cnt_in;
   logic [bdcc_pkg::ALPHA_W-1:0]         alpha_ff, beta_ff;
   logic [bdcc_pkg::GAIN_W-1:0]          gain_ff;
   logic [bdcc_pkg::SAMPLE_BITS-1:0]     norm_ff;
   logic                                 zero_ff;

   logic                                 accept;
   logic                                 merge_free;
   logic                                 merge_load;
   logic [bdcc_pkg::ALPHA_W-1:0]         wr_alpha;
   logic [bdcc_pkg::ALPHA_W-1:0]         wr_alpha_clamp;
   logic [bdcc_pkg::DIV_W-1:0]           divisor;
   bdcc_pkg::bdcc_ctl_type               ctl;
   logic signed [bdcc_pkg::CUR_W-1:0]    cur_x, cur_y, cur_z;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = state_ff != ST_IDLE;
   assign merge_load = (state_ff == ST_FIN) && merge_free;
   assign divisor    = {norm_ff, bdcc_pkg::ALPHA_BITS'(0)};

   // Clamp alpha on write; keep the complementary weight beside it
   assign wr_alpha       = csr_wdata[bdcc_pkg::ALPHA_W-1:0];
   assign wr_alpha_clamp = (wr_alpha > bdcc_pkg::ALPHA_ONE) ? bdcc_pkg::ALPHA_ONE : wr_alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= bdcc_pkg::ALPHA_ONE;
         beta_ff  <= '0;
         gain_ff  <= bdcc_pkg::GAIN_W'(1) << FRACTION_BITS;
      end else if (csr_we) begin
         case (csr_index)
            bdcc_pkg::CSR_FILTER_ALPHA: begin
               alpha_ff <= wr_alpha_clamp;
               beta_ff  <= bdcc_pkg::ALPHA_ONE - wr_alpha_clamp;
            end
            bdcc_pkg::CSR_COIL_GAIN: begin
               gain_ff <= csr_wdata;
            end
            default: begin
               alpha_ff <= alpha_ff;
            end
         endcase
      end
   end

   // Hold the norm and its zero flag for the whole item
   always_ff @(posedge clock) begin
      if (accept) begin
         norm_ff <= req_data.field_norm;
         zero_ff <= req_data.field_norm == '0;
      end
   end

   // Sequencer: one phase a cycle, then one quotient bit a cycle; FIN may stall
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: state_in = ST_MAG;
         ST_MAG: state_in = ST_PLO;
         ST_PLO: state_in = ST_PHI;
         ST_PHI: state_in = ST_ADD;
         ST_ADD: state_in = ST_CHK;
         ST_CHK: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_FIN: begin
            // wait here only while the previous result still sits unread
            if (merge_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      ctl.load = accept;
      ctl.mul  = state_ff == ST_MUL;
      ctl.sum  = state_ff == ST_SUM;
      ctl.mag  = state_ff == ST_MAG;
      ctl.plo  = state_ff == ST_PLO;
      ctl.phi  = state_ff == ST_PHI;
      ctl.add  = state_ff == ST_ADD;
      ctl.chk  = state_ff == ST_CHK;
      ctl.step = state_ff == ST_DIV;
   end

   bdcc_lane u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .alpha      (alpha_ff),
      .beta       (beta_ff),
      .gain       (gain_ff),
      .divisor    (divisor),
      .field      (req_data.field_x),
      .last_field (req_data.last_field_x),
      .current    (cur_x)
   );

   bdcc_lane u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .alpha      (alpha_ff),
      .beta       (beta_ff),
      .gain       (gain_ff),
      .divisor    (divisor),
      .field      (req_data.field_y),
      .last_field (req_data.last_field_y),
      .current    (cur_y)
   );

   bdcc_lane u_lane_z (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .alpha      (alpha_ff),
      .beta       (beta_ff),
      .gain       (gain_ff),
      .divisor    (divisor),
      .field      (req_data.field_z),
      .last_field (req_data.last_field_z),
      .current    (cur_z)
   );

   bdcc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (merge_load),
      .cur_x     (cur_x),
      .cur_y     (cur_y),
      .cur_z     (cur_z),
      .norm_zero (zero_ff),
      .free      (merge_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `BDCC_ASSERT_NEXT(a_accept_starts_lanes, clock, reset, accept,
      state_ff == ST_MUL, "accepted item did not start the lane sequence")
   `BDCC_ASSERT_IMPLY(a_no_result_overwrite, clock, reset, merge_load,
      !(rsp_valid && rsp_stall), "result register loaded over an unread item")
   `BDCC_ASSERT_IMPLY(a_result_from_finish, clock, reset, $rose(rsp_valid),
      $past(state_ff == ST_FIN), "result appeared without a finished item")

endmodule
